@@ design/asre_pkg.sv @@
package asre_pkg;

    localparam int ASRE_MAX_ELEMENTS = 16;
    localparam int ASRE_DATA_W       = 64;

    // Configuration register indexes
    localparam logic REG_ORDER_MODE = 1'b0;
    localparam logic REG_ELEM_BITS  = 1'b1;

    // Order modes
    localparam logic [1:0] MODE_ASCEND  = 2'd0;
    localparam logic [1:0] MODE_DESCEND = 2'd1;
    localparam logic [1:0] MODE_REVERSE = 2'd2;
    localparam logic [1:0] MODE_ARRIVAL = 2'd3;

    // Cell commands
    localparam logic [1:0] OP_HOLD  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SORT  = 2'd2;
    localparam logic [1:0] OP_DRAIN = 2'd3;

    typedef struct packed {
        logic [ASRE_DATA_W-1:0] element;
        logic                   is_last;
    } t_in;

    typedef struct packed {
        logic [ASRE_DATA_W-1:0] out_element;
        logic                   out_last;
    } t_out;

    typedef struct packed {
        logic                   valid;
        logic [ASRE_DATA_W-1:0] value;
    } t_cell_dat;

    typedef struct packed {
        logic [1:0]             op;
        logic                   parity;
        logic [1:0]             mode;
        logic [ASRE_DATA_W-1:0] mask;
    } t_cmd;

    function automatic logic [ASRE_DATA_W-1:0] width_mask(input logic [6:0] w);
        logic [ASRE_DATA_W-1:0] m;
        if (w == 7'd0) begin
            m = '0;
        end else if (w >= 7'(ASRE_DATA_W)) begin
            m = '1;
        end else begin
            m = (ASRE_DATA_W'(1) << w) - ASRE_DATA_W'(1);
        end
        return m;
    endfunction

endpackage

@@ design/array_sort_reverse_engine_core.sv @@
// Throughput: loading shifts each element in at cell 0; the sort runs MAX_ELEMENTS rounds of
// odd-even transposition across the cell chain; results drain at one per cycle unless the
// output stalls. Input stalls outside load, so a new array waits until the last one drains.
// Reset: synchronous active-low; clears count, state and cell valid bits, sets mode 0, width 64.
module array_sort_reverse_engine_core
    import asre_pkg::*;
#(
    parameter int MAX_ELEMENTS = ASRE_MAX_ELEMENTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in        i_data,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output t_out       o_data,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    localparam int TAG_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    // Phases of one array
    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SORT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [TAG_W-1:0] r_round;
    logic [TAG_W-1:0] n_round;
    logic [1:0]       r_order_mode;
    logic [6:0]       r_elem_bits;

    logic             w_in_xfer;
    logic             w_out_xfer;
    logic             w_room;
    t_cmd             w_cmd;

    t_cell_dat        w_dat  [MAX_ELEMENTS];
    logic [TAG_W-1:0] w_tag  [MAX_ELEMENTS];
    logic             w_swap [MAX_ELEMENTS];
    t_cell_dat        w_in_dat;
    t_cell_dat        w_empty;

    // ------------------------------------------------------------------
    // Configuration: always ready; the host must write only while idle, which the block does not enforce
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= MODE_ASCEND;
            r_elem_bits  <= 7'(ASRE_DATA_W);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ORDER_MODE: r_order_mode <= i_cfg_data[1:0];
                REG_ELEM_BITS:  r_elem_bits  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_stall    = (r_state != ST_LOAD);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_room     = (r_count < CNT_W'(MAX_ELEMENTS));

    // Cell 0 is the head of the chain: results leave from there
    assign o_valid    = (r_state == ST_DRAIN) && w_dat[0].valid;
    assign w_out_xfer = o_valid && !i_stall;

    // Mask at the output; the sort already compares masked keys
    assign o_data.out_element = w_dat[0].value & w_cmd.mask;
    if (MAX_ELEMENTS > 1) begin : g_last
        assign o_data.out_last = !w_dat[1].valid;
    end else begin : g_last_one
        assign o_data.out_last = 1'b1;
    end

    // ------------------------------------------------------------------
    // Chain command: insert on load, compare-exchange on sort, shift on drain
    // ------------------------------------------------------------------
    always_comb begin
        w_cmd.op     = OP_HOLD;
        w_cmd.parity = r_round[0];
        w_cmd.mode   = r_order_mode;
        w_cmd.mask   = width_mask(r_elem_bits);
        unique case (r_state)
            ST_LOAD:  if (w_in_xfer && w_room) w_cmd.op = OP_LOAD;
            ST_SORT:  w_cmd.op = OP_SORT;
            ST_DRAIN: if (w_out_xfer) w_cmd.op = OP_DRAIN;
            default:  w_cmd.op = OP_HOLD;
        endcase
    end

    // Control: count, round counter and phase
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_round = r_round;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer) begin
                    // saturate at depth: drop the element, keep the count
                    if (w_room) n_count = r_count + CNT_W'(1);
                    if (i_data.is_last) begin
                        n_state = ST_SORT;
                        n_round = '0;
                    end
                end
            end
            ST_SORT: begin
                n_round = r_round + TAG_W'(1);
                if (r_round == TAG_W'(MAX_ELEMENTS - 1)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (w_out_xfer && o_data.out_last) begin
                    n_state = ST_LOAD;
                    n_count = '0;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_round <= n_round;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain. New elements enter at cell 0 and push older ones up,
    // each tagged with its arrival index for the two order-only modes.
    // ------------------------------------------------------------------
    assign w_in_dat.valid = 1'b1;
    assign w_in_dat.value = i_data.element;
    assign w_empty.valid  = 1'b0;
    assign w_empty.value  = '0;

    for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
        t_cell_dat        w_l_dat;
        logic [TAG_W-1:0] w_l_tag;
        logic             w_l_swap;
        t_cell_dat        w_r_dat;
        logic [TAG_W-1:0] w_r_tag;

        if (k == 0) begin : g_head
            assign w_l_dat  = w_in_dat;
            assign w_l_tag  = r_count[TAG_W-1:0];
            assign w_l_swap = 1'b0;
        end else begin : g_body
            assign w_l_dat  = w_dat[k-1];
            assign w_l_tag  = w_tag[k-1];
            assign w_l_swap = w_swap[k-1];
        end

        if (k == MAX_ELEMENTS - 1) begin : g_tail
            assign w_r_dat = w_empty;
            assign w_r_tag = '0;
        end else begin : g_inner
            assign w_r_dat = w_dat[k+1];
            assign w_r_tag = w_tag[k+1];
        end

        asre_cell #(
            .CELL_IDX (k),
            .TAG_W    (TAG_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left_dat  (w_l_dat),
            .i_left_tag  (w_l_tag),
            .i_left_swap (w_l_swap),
            .i_right_dat (w_r_dat),
            .i_right_tag (w_r_tag),
            .o_dat       (w_dat[k]),
            .o_tag       (w_tag[k]),
            .o_swap      (w_swap[k])
        );
    end

endmodule

@@ design/asre_cell.sv @@
module asre_cell
    import asre_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int TAG_W    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_cell_dat        i_left_dat,
    input  logic [TAG_W-1:0] i_left_tag,
    input  logic             i_left_swap,
    input  t_cell_dat        i_right_dat,
    input  logic [TAG_W-1:0] i_right_tag,
    output t_cell_dat        o_dat,
    output logic [TAG_W-1:0] o_tag,
    output logic             o_swap
);

    localparam logic CELL_PAR = 1'(CELL_IDX % 2);

    t_cell_dat        r_dat;
    t_cell_dat        n_dat;
    logic [TAG_W-1:0] r_tag;
    logic [TAG_W-1:0] n_tag;
    logic [ASRE_DATA_W-1:0] w_own_key;
    logic [ASRE_DATA_W-1:0] w_right_key;
    logic             w_out_of_order;

    assign w_own_key   = r_dat.value & i_cmd.mask;
    assign w_right_key = i_right_dat.value & i_cmd.mask;

    // Pair order: lower cell is emitted first
    always_comb begin
        unique case (i_cmd.mode)
            MODE_ASCEND:  w_out_of_order = w_own_key > w_right_key;
            MODE_DESCEND: w_out_of_order = w_own_key < w_right_key;
            MODE_REVERSE: w_out_of_order = r_tag < i_right_tag;
            MODE_ARRIVAL: w_out_of_order = r_tag > i_right_tag;
            default:      w_out_of_order = 1'b0;
        endcase
    end

    assign o_swap = (i_cmd.op == OP_SORT) && (i_cmd.parity == CELL_PAR) &&
                    r_dat.valid && i_right_dat.valid && w_out_of_order;

    always_comb begin
        n_dat = r_dat;
        n_tag = r_tag;
        unique case (i_cmd.op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                n_dat = i_left_dat;
                n_tag = i_left_tag;
            end
            OP_SORT: begin
                if (o_swap) begin
                    n_dat = i_right_dat;
                    n_tag = i_right_tag;
                end else if (i_left_swap) begin
                    n_dat = i_left_dat;
                    n_tag = i_left_tag;
                end
            end
            OP_DRAIN: begin
                n_dat = i_right_dat;
                n_tag = i_right_tag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dat.valid <= 1'b0;
        end else begin
            r_dat.valid <= n_dat.valid;
        end
        r_dat.value <= n_dat.value;
        r_tag       <= n_tag;
    end

    assign o_dat = r_dat;
    assign o_tag = r_tag;

endmodule
